FILE: rtl/utf8d_pkg.sv
// Shared types and decode functions for the UTF-8 byte stream decoder.
// No dependencies; used by every module under rtl.
package utf8d_pkg;

	localparam int SEQ_MAX     = 4;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [SEQ_MAX-1:0][7:0] seq_t;
	typedef logic [2:0]              cnt_t;
	typedef logic [20:0]             cp_t;
	typedef logic [2:0]              len_t;

	localparam cnt_t CNT_FULL = cnt_t'(SEQ_MAX);
	localparam cnt_t CNT_BOM  = 3'd3;

	localparam logic [7:0] BOM_B0 = 8'hEF;
	localparam logic [7:0] BOM_B1 = 8'hBB;
	localparam logic [7:0] BOM_B2 = 8'hBF;

	// Work item between front and back: an optional flush of the previous
	// sequence (a) and an optional end-of-string result (b).
	typedef struct packed {
		logic a_valid;
		seq_t a_bytes;
		cnt_t a_cnt;
		logic b_valid;
		seq_t b_bytes;
		cnt_t b_cnt;
		logic b_abort;
	} cmd_t;

	function automatic logic is_bom(input seq_t s, input cnt_t n);
		return (n == CNT_BOM) && (s[0] == BOM_B0) && (s[1] == BOM_B1) && (s[2] == BOM_B2);
	endfunction

	function automatic cp_t decode(input seq_t s, input cnt_t n);
		cp_t cp;
		cp = '0;
		unique case (n)
			3'd1: cp = {14'd0, s[0][6:0]};
			3'd2: cp = {10'd0, s[0][4:0], s[1][5:0]};
			3'd3: cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
			3'd4: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
			default: cp = '0;
		endcase
		return cp;
	endfunction

	function automatic len_t enc_len(input cp_t cp);
		len_t l;
		if (cp < cp_t'(21'h80)) begin
			l = 3'd1;
		end else if (cp < cp_t'(21'h800)) begin
			l = 3'd2;
		end else if (cp < cp_t'(21'h10000)) begin
			l = 3'd3;
		end else begin
			l = 3'd4;
		end
		return l;
	endfunction

endpackage

FILE: rtl/utf8d_front.sv
// Front end: accepts bytes, collects sequences and emits flush commands.
// Depends on utf8d_pkg.
module utf8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] byte_value
	input  logic              s_tlast,  // end_of_input
	input  logic              q_full,
	output logic              q_push,
	output utf8d_pkg::cmd_t   q_cmd
);

	utf8d_pkg::seq_t seq_q, nxt_seq;
	utf8d_pkg::cnt_t cnt_q, nxt_cnt;
	logic            dropping_q, nxt_drop;
	logic            accept, is_start;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_start = !s_tdata[7] || (s_tdata[7:6] == 2'b11);

	always_comb begin
		q_cmd    = '0;
		nxt_seq  = seq_q;
		nxt_cnt  = cnt_q;
		nxt_drop = dropping_q;
		if (dropping_q) begin
			if (s_tlast) begin
				nxt_drop = 1'b0;
				nxt_cnt  = '0;
			end
		end else if (!is_start && (cnt_q == utf8d_pkg::CNT_FULL)) begin
			q_cmd.b_valid = 1'b1;
			q_cmd.b_abort = 1'b1;
			nxt_cnt       = '0;
			nxt_drop      = !s_tlast;
		end else begin
			if (is_start) begin
				q_cmd.a_valid = (cnt_q != '0);
				q_cmd.a_bytes = seq_q;
				q_cmd.a_cnt   = cnt_q;
				nxt_seq[0]    = s_tdata;
				nxt_cnt       = 3'd1;
			end else begin
				nxt_seq[cnt_q[1:0]] = s_tdata;
				nxt_cnt             = cnt_q + 3'd1;
			end
			if (s_tlast) begin
				q_cmd.b_valid = 1'b1;
				q_cmd.b_bytes = nxt_seq;
				q_cmd.b_cnt   = nxt_cnt;
				nxt_cnt       = '0;
			end
		end
	end

	assign q_push = accept && (q_cmd.a_valid || q_cmd.b_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			dropping_q <= 1'b0;
		end else if (accept) begin
			cnt_q      <= nxt_cnt;
			dropping_q <= nxt_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= nxt_seq;
		end
	end

endmodule

FILE: rtl/utf8d_queue.sv
// Small command queue between front and back.
// Depends on utf8d_pkg.
module utf8d_queue #(
	parameter int Depth = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utf8d_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output utf8d_pkg::cmd_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	utf8d_pkg::cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

FILE: rtl/utf8d_back.sv
// Back end: decodes queued commands and drives the result beats.
// Depends on utf8d_pkg.
module utf8d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  utf8d_pkg::cmd_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,  // [20:0] codepoint, [23:21] encoded_bytes
	output logic            m_tlast,  // end_of_string
	output logic [1:0]      m_tuser   // [0] has_codepoint, [1] aborted
);

	logic              m_tvalid_q, has_q, eos_q, ab_q, phase_q;
	utf8d_pkg::cp_t    cp_q;
	utf8d_pkg::len_t   len_q;

	logic              out_free, sel_a, load, nxt_phase;
	logic              r_has, r_eos, r_ab;
	utf8d_pkg::cp_t    r_cp, a_cp, b_cp;
	logic              a_bom, b_bom;

	assign out_free = !m_tvalid_q || m_tready;
	assign sel_a    = !phase_q && q_head.a_valid;
	assign a_bom    = utf8d_pkg::is_bom(q_head.a_bytes, q_head.a_cnt);
	assign b_bom    = utf8d_pkg::is_bom(q_head.b_bytes, q_head.b_cnt);
	assign a_cp     = utf8d_pkg::decode(q_head.a_bytes, q_head.a_cnt);
	assign b_cp     = utf8d_pkg::decode(q_head.b_bytes, q_head.b_cnt);

	always_comb begin
		q_pop     = 1'b0;
		load      = 1'b0;
		nxt_phase = phase_q;
		r_has     = 1'b0;
		r_cp      = '0;
		r_eos     = 1'b0;
		r_ab      = 1'b0;
		if (!q_empty && out_free) begin
			if (sel_a) begin
				load      = !a_bom;
				r_has     = 1'b1;
				r_cp      = a_cp;
				q_pop     = !q_head.b_valid;
				nxt_phase = q_head.b_valid;
			end else begin
				load      = 1'b1;
				r_eos     = 1'b1;
				r_ab      = q_head.b_abort;
				r_has     = !q_head.b_abort && !b_bom;
				r_cp      = r_has ? b_cp : '0;
				q_pop     = 1'b1;
				nxt_phase = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			phase_q <= nxt_phase;
			if (out_free) begin
				m_tvalid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			has_q <= r_has;
			cp_q  <= r_cp;
			len_q <= r_has ? utf8d_pkg::enc_len(r_cp) : '0;
			eos_q <= r_eos;
			ab_q  <= r_ab;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {len_q, cp_q};
	assign m_tlast  = eos_q;
	assign m_tuser  = {ab_q, has_q};

endmodule

FILE: rtl/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: front, command queue, back.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
//
//   channel | dir | tdata                          | tlast          | tuser
//   s_      | in  | [7:0] byte_value               | end_of_input   | -
//   m_      | out | [20:0] codepoint,              | end_of_string  | [0] has_codepoint,
//           |     | [23:21] encoded_bytes          |                | [1] aborted
//
// One byte per cycle in while the queue is not full; results pass through the command queue
// and the output register and leave one beat per cycle while m_tready is high. A final byte that
// also flushes an earlier sequence yields two beats in turn (one if that sequence is EF BB BF).
// The output register and the command queue let the input run while m_tready is low until the queue fills.
// Reset clears the sequence count, drop flag, queue and output valid; no clearing pass.
module utf8_byte_stream_decoder #(
	parameter int QueueDepth = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] codepoint, [23:21] encoded_bytes
	output logic        m_tlast,   // end_of_string
	output logic [1:0]  m_tuser    // [0] has_codepoint, [1] aborted
);

	utf8d_pkg::cmd_t push_cmd, head;
	logic            push, full, pop, empty;

	utf8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	utf8d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	utf8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_head   (head),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
